@@ sv/edfq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the EDF ready queue.
// No dependencies; imported by the controller, the datapath and the top level.
package edfq_pkg;

	// Range of task ids carried by the six-bit task id field
	localparam int TASK_ID_SPACE = 64;

	// Item modes
	localparam logic [1:0] MODE_ENQ  = 2'd0;
	localparam logic [1:0] MODE_DEQ  = 2'd1;
	localparam logic [1:0] MODE_PICK = 2'd2;

	// Result status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_QUEUED  = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [5:0]  task_id;
		logic [31:0] deadline;
	} slot_t;

	// Controller to datapath
	typedef struct packed {
		logic load;    // latch the incoming word
		logic check;   // evaluate the admission checks
		logic step;    // process one slot of the walk
		logic at_end;  // walk index has reached the queue length
		logic rd_en;   // issue a slot read
		logic finish;  // commit the result and the queue updates
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic walk;    // item needs a walk over the slots
		logic stop;    // pick has found its task at this slot
	} stat_t;

endpackage

@@ sv/edfq_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the EDF ready queue: item sequencing and slot walk index.
// Depends on edfq_pkg.
module edfq_ctrl #(
	parameter int QUEUE_DEPTH = 16,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	output logic            done,
	input  edfq_pkg::stat_t st,
	input  logic [CW-1:0]   count,
	output edfq_pkg::cmd_t  cmd,
	output logic [CW-1:0]   idx,
	output logic [AW-1:0]   rd_addr
);
	import edfq_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WALK
	} state_t;

	state_t        state_q;
	logic [CW-1:0] idx_q;
	logic          done_q;
	logic [CW-1:0] idx_nxt;

	assign idx_nxt = idx_q + CW'(1);

	always_comb begin
		cmd     = '0;
		rd_addr = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_CHECK: begin
				cmd.check  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.finish = !st.walk;
			end
			S_WALK: begin
				cmd.step   = 1'b1;
				cmd.at_end = (idx_q == count);
				cmd.rd_en  = 1'b1;
				rd_addr    = idx_nxt[AW-1:0];
				cmd.finish = cmd.at_end || st.stop;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CHECK;
				end
				S_CHECK: begin
					idx_q   <= '0;
					state_q <= cmd.finish ? S_IDLE : S_WALK;
				end
				S_WALK: begin
					if (cmd.finish) state_q <= S_IDLE;
					else idx_q <= idx_nxt;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign idx  = idx_q;

endmodule

@@ sv/edfq_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the EDF ready queue: slot memory, queued flags, length, results.
// Depends on edfq_pkg; driven by edfq_ctrl.
module edfq_datapath #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_COUNT = 64,
	localparam int AW = $clog2(QUEUE_DEPTH),
	localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  edfq_pkg::cmd_t  cmd,
	input  logic [CW-1:0]   idx,
	input  logic [AW-1:0]   rd_addr,
	output edfq_pkg::stat_t st,
	output logic [CW-1:0]   count,
	input  logic            cfg_we,
	input  logic [5:0]      cfg_data,
	input  logic [1:0]      mode,
	input  logic [5:0]      task_id,
	input  logic [31:0]     task_deadline,
	input  logic [63:0]     now_time,
	output logic [5:0]      picked_task,
	output logic            picked_idle,
	output logic [1:0]      status,
	output logic [4:0]      queue_length
);
	import edfq_pkg::*;

	// Latched word
	logic [1:0]  mode_q;
	logic [5:0]  id_q;
	logic [31:0] dl_q;
	logic [63:0] now_q;

	logic [5:0]               idle_task_q;
	logic [CW-1:0]            count_q;
	logic [TASK_ID_SPACE-1:0] queued_q;

	slot_t mem [QUEUE_DEPTH];
	slot_t rd_q;
	slot_t hold_q;
	logic [5:0] task0_q;
	logic ins_q, nxt_q, found_q;

	logic [5:0] picked_task_q;
	logic       picked_idle_q;
	logic [1:0] status_q;

	// Admission checks
	logic       id_bad, is_queued, full;
	logic       pre_walk, pre_idle;
	logic [1:0] pre_status;

	// Walk
	logic          now_hi_zero, d_gt, d_ge, pick_stop, enq_here;
	logic          walk_end;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	slot_t         wr_data;
	slot_t         new_slot;
	logic [CW-1:0] idx_m1;

	assign id_bad    = (32'(id_q) >= TASK_COUNT);
	assign is_queued = queued_q[id_q] || (id_q == idle_task_q);
	assign full      = (count_q == CW'(QUEUE_DEPTH));

	always_comb begin
		pre_walk   = 1'b0;
		pre_idle   = 1'b0;
		pre_status = ST_DONE;
		unique case (mode_q)
			MODE_ENQ: begin
				if (id_bad) pre_status = ST_IGNORED;
				else if (is_queued) pre_status = ST_QUEUED;
				else if (full) pre_status = ST_FULL;
				else pre_walk = 1'b1;
			end
			MODE_DEQ: begin
				if (id_bad || id_q == idle_task_q || !queued_q[id_q]) pre_status = ST_IGNORED;
				else pre_walk = 1'b1;
			end
			MODE_PICK: begin
				if (count_q == '0) pre_idle = 1'b1;
				else pre_walk = 1'b1;
			end
			default: begin
				pre_status = ST_IGNORED;
			end
		endcase
	end

	// Deadlines are zero-extended against the 64-bit time
	assign now_hi_zero = (now_q[63:32] == 32'd0);
	assign d_gt        = now_hi_zero && (rd_q.deadline > now_q[31:0]);
	assign d_ge        = now_hi_zero && (rd_q.deadline >= now_q[31:0]);
	assign walk_end    = (idx == count_q);
	assign pick_stop   = (mode_q == MODE_PICK) && !walk_end && ((idx == '0) ? d_gt : d_ge);

	assign st.walk = pre_walk;
	assign st.stop = pick_stop;

	assign new_slot = '{task_id: id_q, deadline: dl_q};
	assign enq_here = !ins_q && (nxt_q || (dl_q < rd_q.deadline));
	assign idx_m1   = idx - CW'(1);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx[AW-1:0];
		wr_data = hold_q;
		if (cmd.step && mode_q == MODE_ENQ) begin
			if (cmd.at_end) begin
				wr_en   = 1'b1;
				wr_data = ins_q ? hold_q : new_slot;
			end else if (ins_q) begin
				wr_en = 1'b1;
			end else if (enq_here) begin
				wr_en   = 1'b1;
				wr_data = new_slot;
			end
		end else if (cmd.step && mode_q == MODE_DEQ && found_q && !cmd.at_end) begin
			// close the gap: move this slot down by one
			wr_en   = 1'b1;
			wr_addr = idx_m1[AW-1:0];
			wr_data = rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_q <= mem[rd_addr];
	end

	// Word latch and walk carry
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			id_q   <= task_id;
			dl_q   <= task_deadline;
			now_q  <= now_time;
		end
		if (cmd.step && !cmd.at_end) begin
			if (mode_q == MODE_ENQ && (ins_q || enq_here)) hold_q <= rd_q;
			if (mode_q == MODE_PICK && idx == '0) task0_q <= rd_q.task_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_task_q <= '0;
			count_q     <= '0;
			queued_q    <= '0;
			ins_q       <= 1'b0;
			nxt_q       <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_we) idle_task_q <= cfg_data;
			if (cmd.check) begin
				ins_q   <= 1'b0;
				nxt_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.step && !cmd.at_end) begin
				if (mode_q == MODE_ENQ) begin
					if (enq_here) ins_q <= 1'b1;
					else if (!ins_q && dl_q == rd_q.deadline) nxt_q <= 1'b1;
				end
				if (mode_q == MODE_DEQ && rd_q.task_id == id_q) found_q <= 1'b1;
			end
			if (cmd.step && cmd.finish) begin
				if (mode_q == MODE_ENQ) begin
					count_q        <= count_q + CW'(1);
					queued_q[id_q] <= 1'b1;
				end else if (mode_q == MODE_DEQ) begin
					queued_q[id_q] <= 1'b0;
					if (found_q) count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// Result word
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			if (cmd.check) begin
				status_q      <= pre_status;
				picked_idle_q <= pre_idle;
				picked_task_q <= pre_idle ? idle_task_q : 6'd0;
			end else begin
				status_q      <= ST_DONE;
				picked_idle_q <= 1'b0;
				if (mode_q == MODE_PICK) picked_task_q <= pick_stop ? rd_q.task_id : task0_q;
				else picked_task_q <= 6'd0;
			end
		end
	end

	assign count        = count_q;
	assign picked_task  = picked_task_q;
	assign picked_idle  = picked_idle_q;
	assign status       = status_q;
	assign queue_length = 5'(count_q);

endmodule

@@ sv/edf_sorted_ready_queue.sv @@
`timescale 1ns / 1ps
// Top level of the earliest-deadline-first ready queue.
// Depends on edfq_pkg, edfq_ctrl and edfq_datapath.
//
//  Channel  | Handshake                 | Word
//  ---------+---------------------------+------------------------------------------
//  item     | start / busy              | mode, task_id, task_deadline, now_time
//  result   | done (one-cycle strobe)   | picked_task, picked_idle, status, queue_length
//  config   | cfg_valid / cfg_ready     | cfg_data (idle task id)
//
// An item is taken when start is high and busy is low. The check state follows;
// a word settled there (refused, ignored, mode three, pick on an empty queue)
// shows its result in the cycle after the check. Otherwise the item walks the
// sorted slots one per cycle through the single read port of the slot memory:
// up to queue length plus one slots; a pick stops at the slot it chooses, or
// walks to the end and takes the task at slot zero.
// Reset clears the queue length, the queued flags and the idle task; slot
// contents stay as they are. The receiver cannot stall: done is high for one
// cycle and the word holds until the next result. cfg_ready is always high.
module edf_sorted_ready_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TASK_COUNT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [5:0]  task_id,
	input  logic [31:0] task_deadline,
	input  logic [63:0] now_time,
	// result channel
	output logic        done,
	output logic [5:0]  picked_task,
	output logic        picked_idle,
	output logic [1:0]  status,
	output logic [4:0]  queue_length,
	// configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);
	import edfq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          cmd;
	stat_t         st;
	logic [CW-1:0] count;
	logic [CW-1:0] idx;
	logic [AW-1:0] rd_addr;

	// Writes must only arrive while idle (the user's duty, not enforced here), so take them at once
	assign cfg_ready = 1'b1;

	edfq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.st     (st),
		.count  (count),
		.cmd    (cmd),
		.idx    (idx),
		.rd_addr(rd_addr)
	);

	edfq_datapath #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TASK_COUNT (TASK_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.rd_addr      (rd_addr),
		.st           (st),
		.count        (count),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.task_id      (task_id),
		.task_deadline(task_deadline),
		.now_time     (now_time),
		.picked_task  (picked_task),
		.picked_idle  (picked_idle),
		.status       (status),
		.queue_length (queue_length)
	);

endmodule
